>>> hw/rtl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

    // Operand width of base, exponent, modulus and result
    localparam int OPERAND_WIDTH = 32;

    // APB data width and register addressing
    localparam int APB_DATA_WIDTH = (OPERAND_WIDTH > 32) ? 64 : 32;
    localparam int APB_ADDR_LSB   = (APB_DATA_WIDTH > 32) ? 3 : 2;
    localparam int APB_ADDR_WIDTH = APB_ADDR_LSB + 1;

    // Register index of the modulus
    localparam logic [0:0] REG_MODULUS = 1'b0;

    // Step counter of the multiply-reduce unit
    localparam int STEP_CNT_WIDTH = $clog2(OPERAND_WIDTH);
    localparam logic [STEP_CNT_WIDTH-1:0] STEP_LAST = STEP_CNT_WIDTH'(OPERAND_WIDTH - 1);

    typedef logic [OPERAND_WIDTH-1:0] word_t;

    localparam word_t WORD_ONE = word_t'(1);

    // Request to the shared multiply-reduce unit
    typedef struct packed {
        logic  start;
        word_t op_a;
        word_t op_b;
    } mm_ctrl_t;

    // Status back from the multiply-reduce unit
    typedef struct packed {
        logic  busy;
        logic  done;
        word_t result;
    } mm_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/modular_exponentiation.sv
// Top level: square-and-multiply sequencer around the shared modular multiplier.
`default_nettype none

// Computes power = base^exponent mod modulus, scanning the exponent from its
// least significant bit. The modulus is an APB register at byte address 0
// (reset 1; a write of zero is ignored). Exponent zero returns 1 even when the
// modulus is 1. Each request is handled alone: in_ready is high only while the
// sequencer is idle. All arithmetic goes through one shift-and-add multiply-
// reduce unit that retires one multiplier bit per cycle. A request needs one
// base reduction, one multiplication per set exponent bit and one squaring
// per exponent bit below the top set bit. The result sits in an output
// register, so the next request is accepted as soon as the result is handed
// over or stored there.
module modular_exponentiation (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mexp_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  wire logic [mexp_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic      [mexp_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                      pready,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire mexp_pkg::word_t                      base,
    input  wire mexp_pkg::word_t                      exponent,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output mexp_pkg::word_t                           power
);

    localparam int W = mexp_pkg::OPERAND_WIDTH;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_REDUCE   = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_MUL      = 3'd3;
    localparam logic [2:0] S_SQR      = 3'd4;
    localparam logic [2:0] S_OUT      = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    mexp_pkg::word_t     acc_reg, acc_next;
    mexp_pkg::word_t     base_reg, base_next;
    mexp_pkg::word_t     exp_reg, exp_next;
    mexp_pkg::word_t     power_reg, power_next;
    mexp_pkg::word_t     modulus;
    mexp_pkg::mm_ctrl_t  mm_ctrl;
    mexp_pkg::mm_stat_t  mm_stat;

    mexp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .modulus (modulus)
    );

    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mm_ctrl),
        .modulus (modulus),
        .stat    (mm_stat)
    );

    // Square-and-multiply sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        power_next     = power_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mm_ctrl.start  = 1'b0;
        mm_ctrl.op_a   = acc_reg;
        mm_ctrl.op_b   = base_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // base mod m, computed as 1 * base through the multiplier
                    exp_next      = exponent;
                    acc_next      = mexp_pkg::WORD_ONE;
                    mm_ctrl.start = 1'b1;
                    mm_ctrl.op_a  = mexp_pkg::WORD_ONE;
                    mm_ctrl.op_b  = base;
                    state_next    = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (mm_stat.done)
                begin
                    base_next  = mm_stat.result;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (exp_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else if (exp_reg[0])
                begin
                    mm_ctrl.start = 1'b1;
                    mm_ctrl.op_a  = acc_reg;
                    mm_ctrl.op_b  = base_reg;
                    state_next    = S_MUL;
                end
                else
                begin
                    mm_ctrl.start = 1'b1;
                    mm_ctrl.op_a  = base_reg;
                    mm_ctrl.op_b  = base_reg;
                    state_next    = S_SQR;
                end
            end
            S_MUL:
            begin
                if (mm_stat.done)
                begin
                    acc_next   = mm_stat.result;
                    exp_next   = {exp_reg[W-1:1], 1'b0};
                    state_next = S_DISPATCH;
                end
            end
            S_SQR:
            begin
                if (mm_stat.done)
                begin
                    base_next  = mm_stat.result;
                    exp_next   = {1'b0, exp_reg[W-1:1]};
                    state_next = S_DISPATCH;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    power_next     = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        exp_reg   <= exp_next;
        power_reg <= power_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign power     = power_reg;

    // The multiplier is never running while a new request can be taken
    a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mm_stat.busy)
        else $error("multiplier busy while sequencer idle");

    // Completions only arrive while the sequencer waits for one
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mm_stat.done |-> (state_reg == S_REDUCE || state_reg == S_MUL ||
                          state_reg == S_SQR))
        else $error("unexpected multiplier completion");

    // Every multiplier result is fully reduced
    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        mm_stat.done |-> (mm_stat.result < modulus))
        else $error("multiplier result not below modulus");

    // A delivered power is reduced, or the unreduced one of a zero exponent
    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (power < modulus || power == mexp_pkg::WORD_ONE))
        else $error("power out of range");

endmodule

`default_nettype wire

>>> hw/rtl/mexp_regs.sv
// APB configuration register file holding the modulus.
`default_nettype none

module mexp_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mexp_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  wire logic [mexp_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic      [mexp_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                      pready,
    output mexp_pkg::word_t                           modulus
);

    mexp_pkg::word_t modulus_reg;
    mexp_pkg::word_t modulus_next;
    mexp_pkg::word_t wr_value;
    logic            reg_sel;
    logic            wr_en;

    assign reg_sel  = (paddr[mexp_pkg::APB_ADDR_WIDTH-1] == mexp_pkg::REG_MODULUS);
    assign wr_en    = psel && penable && pwrite && pready;
    assign wr_value = pwdata[mexp_pkg::OPERAND_WIDTH-1:0];
    assign pready   = 1'b1;

    // Modulus write; a zero value is dropped so the modulus never becomes zero
    always_comb
    begin
        modulus_next = modulus_reg;
        if (wr_en && reg_sel && (wr_value != '0))
        begin
            modulus_next = wr_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= mexp_pkg::WORD_ONE;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata[mexp_pkg::OPERAND_WIDTH-1:0] = modulus_reg;
        end
    end

    assign modulus = modulus_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mexp_mulmod.sv
// Iterative shift-and-add modular multiplier, one multiplier bit per cycle.
`default_nettype none

module mexp_mulmod (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mexp_pkg::mm_ctrl_t ctrl,
    input  wire mexp_pkg::word_t    modulus,
    output mexp_pkg::mm_stat_t      stat
);

    localparam int W = mexp_pkg::OPERAND_WIDTH;

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [mexp_pkg::STEP_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    mexp_pkg::word_t                     acc_reg, acc_next;
    mexp_pkg::word_t                     a_reg, a_next;
    mexp_pkg::word_t                     b_reg, b_next;

    mexp_pkg::word_t                     addend;
    logic [W+1:0]                        sum;
    logic [W+1:0]                        mod1;
    logic [W+1:0]                        mod2;
    logic [W+1:0]                        reduced;

    // One step: acc = (2*acc + bit*a) mod m; the sum stays below 3m
    always_comb
    begin
        addend = b_reg[W-1] ? a_reg : '0;
        sum    = {1'b0, acc_reg, 1'b0} + {2'b00, addend};
        mod1   = {2'b00, modulus};
        mod2   = {1'b0, modulus, 1'b0};
        priority if (sum >= mod2)
        begin
            reduced = sum - mod2;
        end
        else if (sum >= mod1)
        begin
            reduced = sum - mod1;
        end
        else
        begin
            reduced = sum;
        end
    end

    // Step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        priority if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            a_next    = ctrl.op_a;
            b_next    = ctrl.op_b;
        end
        else if (busy_reg)
        begin
            acc_next = reduced[W-1:0];
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mexp_pkg::STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign stat.busy   = busy_reg;
    assign stat.done   = done_reg;
    assign stat.result = acc_reg;

endmodule

`default_nettype wire

>>> verif/modular_exponentiation_tb.sv
// Testbench for modular_exponentiation: directed and random requests checked against a predictor.
module modular_exponentiation_tb;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int HOLD_CYCLES   = 4000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_ITEMS   = 30;

    // Unmapped register index, one past the modulus
    localparam logic [0:0] REG_UNMAPPED = 1'b1;

    localparam mexp_pkg::word_t WORD_MAX = '1;

    // One expected result, with the operands kept for the report
    typedef struct {
        mexp_pkg::word_t base;
        mexp_pkg::word_t exponent;
        mexp_pkg::word_t power;
    } power_check_t;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                psel      = 1'b0;
    logic                                penable   = 1'b0;
    logic                                pwrite    = 1'b0;
    logic [mexp_pkg::APB_ADDR_WIDTH-1:0] paddr     = '0;
    logic [mexp_pkg::APB_DATA_WIDTH-1:0] pwdata    = '0;
    logic [mexp_pkg::APB_DATA_WIDTH-1:0] prdata;
    logic                                pready;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    mexp_pkg::word_t                     base      = '0;
    mexp_pkg::word_t                     exponent  = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    mexp_pkg::word_t                     power;

    // Predictor state and bookkeeping
    mexp_pkg::word_t cur_modulus = mexp_pkg::WORD_ONE;
    power_check_t    pending_powers[$];
    int              power_errors    = 0;
    int              readback_errors = 0;
    int              cycle_count     = 0;

    // Idling controls
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requested = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    modular_exponentiation u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .base      (base),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .power     (power)
    );

    // Clock
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("modular_exponentiation: mismatch");
            $finish;
        end
    end

    // Result side: long hold-off on request, else random stalls
    always @(posedge clk)
    begin
        if (hold_requested != hold_served)
        begin
            hold_served <= hold_requested;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // base^exponent mod m, right to left; exponent zero gives 1 unreduced
    function automatic mexp_pkg::word_t expected_power(input mexp_pkg::word_t b,
                                                       input mexp_pkg::word_t e,
                                                       input mexp_pkg::word_t m);
        logic [2*mexp_pkg::OPERAND_WIDTH-1:0] acc;
        logic [2*mexp_pkg::OPERAND_WIDTH-1:0] sq;
        mexp_pkg::word_t                      bits;
        if (e == '0)
            return mexp_pkg::WORD_ONE;
        acc  = 1 % m;
        sq   = b % m;
        bits = e;
        while (bits != '0)
        begin
            if (bits[0])
                acc = (acc * sq) % m;
            sq   = (sq * sq) % m;
            bits = bits >> 1;
        end
        return mexp_pkg::word_t'(acc);
    endfunction

    // Check each result against the oldest expectation, then log new requests
    always @(posedge clk)
    begin : check_results
        power_check_t head;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_powers.size() == 0)
            begin
                power_errors++;
                $display("%0t: unexpected result: expected none, actual power %h",
                         $time, power);
            end
            else
            begin
                head = pending_powers.pop_front();
                if (power !== head.power)
                begin
                    power_errors++;
                    $display("%0t: power wrong (base %h exponent %h): expected %h, actual %h",
                             $time, head.base, head.exponent, head.power, power);
                end
            end
        end
        if (rst_n && in_valid && in_ready)
            pending_powers.push_back('{base, exponent,
                                       expected_power(base, exponent, cur_modulus)});
    end

    // APB write; a zero modulus or an unmapped index leaves the register as is
    task automatic reg_write(input logic [0:0] index, input mexp_pkg::word_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mexp_pkg::APB_ADDR_WIDTH'(index) << mexp_pkg::APB_ADDR_LSB;
        pwdata  <= mexp_pkg::APB_DATA_WIDTH'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (index == mexp_pkg::REG_MODULUS && value != '0)
            cur_modulus = value;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // APB read of the modulus, compared with the predicted value
    task automatic modulus_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= mexp_pkg::APB_ADDR_WIDTH'(mexp_pkg::REG_MODULUS) << mexp_pkg::APB_ADDR_LSB;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[mexp_pkg::OPERAND_WIDTH-1:0] !== cur_modulus)
        begin
            readback_errors++;
            $display("%0t: modulus readback wrong: expected %h, actual %h",
                     $time, cur_modulus, prdata[mexp_pkg::OPERAND_WIDTH-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one request after a random gap; valid stays up until accepted
    task automatic send_request(input mexp_pkg::word_t b, input mexp_pkg::word_t e);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        base     <= b;
        exponent <= e;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop sending and wait until every expected result is back; the extra
    // edge lets the checker log the last accepted request first
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_powers.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic test_reset_state();
        modulus_readback();
        send_request(32'd5, '0);
        send_request(WORD_MAX, WORD_MAX);
        send_request(32'd7, 32'd3);
        wait_drained();
    endtask

    task automatic test_directed_extremes();
        reg_write(mexp_pkg::REG_MODULUS, WORD_MAX);
        modulus_readback();
        send_request('0, '0);
        send_request('0, 32'd1);
        send_request('0, WORD_MAX);
        send_request(32'd1, WORD_MAX);
        send_request(WORD_MAX, 32'd1);
        send_request(WORD_MAX - 1, 32'd2);
        send_request(WORD_MAX - 1, WORD_MAX);
        send_request(32'd2, 32'd31);
        send_request(32'd2, 32'd32);
        send_request(32'd3, 32'h8000_0000);
        send_request(32'h1234_5678, 32'h5555_5555);
        wait_drained();
        // largest 32-bit prime; base above the modulus and a Fermat case
        reg_write(mexp_pkg::REG_MODULUS, 32'hFFFF_FFFB);
        send_request(WORD_MAX, 32'd1);
        send_request(WORD_MAX, WORD_MAX);
        send_request(32'hFFFF_FFFA, 32'hFFFF_FFFA);
        send_request(32'd2, 32'hFFFF_FFFA);
        wait_drained();
        reg_write(mexp_pkg::REG_MODULUS, 32'd2);
        send_request(32'd3, WORD_MAX);
        send_request(32'd2, '0);
        send_request(32'd1, 32'hAAAA_AAAA);
        wait_drained();
    endtask

    task automatic test_register_guards();
        // zero modulus and unmapped index are both ignored
        reg_write(mexp_pkg::REG_MODULUS, '0);
        modulus_readback();
        reg_write(REG_UNMAPPED, 32'd77);
        modulus_readback();
        send_request(32'd3, 32'd5);
        wait_drained();
        // modulus 1: zero exponent still gives 1
        reg_write(mexp_pkg::REG_MODULUS, 32'd1);
        modulus_readback();
        send_request(32'd9, 32'd7);
        send_request(32'd9, '0);
        wait_drained();
    endtask

    // Random requests: operands near the modulus, exponents of random length
    task automatic random_traffic(input int count);
        mexp_pkg::word_t b;
        mexp_pkg::word_t e;
        repeat (count)
        begin
            case ($urandom_range(7))
                0:       b = '0;
                1:       b = WORD_MAX;
                2:       b = cur_modulus - 1;
                3:       b = cur_modulus;
                4:       b = cur_modulus + mexp_pkg::word_t'($urandom_range(5));
                default: b = $urandom;
            endcase
            case ($urandom_range(9))
                0:       e = '0;
                1:       e = WORD_MAX;
                2:       e = 32'd1;
                default: e = $urandom >> $urandom_range(31);
            endcase
            send_request(b, e);
        end
    endtask

    task automatic test_random_phases();
        int              tx_pcts[4] = '{0, 67, 0, 33};
        int              rx_pcts[4] = '{0, 0, 67, 33};
        mexp_pkg::word_t m;
        for (int phase = 0; phase < 4; phase++)
        begin
            tx_idle_pct  = tx_pcts[phase];
            rx_stall_pct = rx_pcts[phase];
            for (int half = 0; half < 2; half++)
            begin
                case (phase * 2 + half)
                    0:       m = WORD_MAX;
                    1:       m = $urandom | 32'h8000_0000;
                    2:       m = $urandom_range(2, 1000);
                    3:       m = $urandom;
                    4:       m = $urandom_range(1, 3);
                    5:       m = $urandom >> $urandom_range(31);
                    6:       m = 32'hFFFF_FFFB;
                    default: m = $urandom;
                endcase
                reg_write(mexp_pkg::REG_MODULUS, m);
                random_traffic(PHASE_ITEMS);
                wait_drained();
            end
        end
    endtask

    // Long result hold-off with a steady sender: the block fills and stalls
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        reg_write(mexp_pkg::REG_MODULUS, $urandom | 32'h8000_0000);
        hold_requested = hold_requested + 1;
        repeat (12)
            send_request($urandom, $urandom_range(255));
        wait_drained();
        tx_idle_pct  = 33;
        rx_stall_pct = 33;
        random_traffic(4);
        wait_drained();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_extremes();
        test_register_guards();
        test_random_phases();
        test_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (power_errors == 0 && readback_errors == 0 && pending_powers.size() == 0)
            $display("modular_exponentiation: match");
        else
            $display("modular_exponentiation: mismatch");
        $finish;
    end

endmodule
